[design/line_follow_steering_defines.svh]
// ----------------------------------------------------------------------------
// Line follow steering: assertion macros
// Shared property forms used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_STEERING_DEFINES_SVH
`define LINE_FOLLOW_STEERING_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset
`define LFS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication after a fixed number of cycles
`define LFS_ASSERT_DLY(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

[design/lfs_pkg.sv]
// ----------------------------------------------------------------------------
// lfs_pkg
// Types, constants and the sine/cosine tables of the line follow steering block.
// ----------------------------------------------------------------------------
package lfs_pkg;

	// Field widths
	localparam int unsigned SAMPLE_W = 8;
	localparam int unsigned POWER_W  = 7;
	localparam int unsigned CFG_W    = 8;
	localparam int unsigned CFG_IDX_W = 3;

	// Angle search: 7 binary steps cover 0..127, angles above 89 never pass
	localparam int unsigned ANGLE_STEPS = 7;
	localparam int unsigned ANG_W       = ANGLE_STEPS;
	localparam int unsigned ANGLE_MAX   = 89;
	localparam int unsigned ANGLE_VERT  = 90;
	localparam int unsigned TAB_DEPTH   = 1 << ANG_W;
	localparam int unsigned TRIG_W      = 31;

	// Power limit and pipeline stage count (front 2, cells, mix 4, output 1)
	localparam int unsigned POWER_MAX    = 100;
	localparam int unsigned PIPE_LATENCY = 2 + ANGLE_STEPS + 5;

	// Reciprocal constants for divide by ten and by a hundred
	localparam int unsigned RECIP10      = 6554;
	localparam int unsigned RECIP10_SH   = 16;
	localparam int unsigned RECIP100     = 5243;
	localparam int unsigned RECIP100_SH  = 19;

	typedef enum logic [1:0] {
		MODE_STRAIGHT = 2'd0,
		MODE_SPIN     = 2'd1,
		MODE_STEER    = 2'd2
	} drive_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WHITE_LEFT  = 3'd0,
		CFG_WHITE_RIGHT = 3'd1,
		CFG_BLACK_LEFT  = 3'd2,
		CFG_BLACK_RIGHT = 3'd3,
		CFG_NEAR_LIMIT  = 3'd4,
		CFG_OFF_LIMIT   = 3'd5,
		CFG_FWD_SPEED   = 3'd6,
		CFG_STEER_GAIN  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left_sample;
		logic [SAMPLE_W-1:0] right_sample;
	} in_item_t;

	typedef struct packed {
		logic [POWER_W-1:0] left_power;
		logic [POWER_W-1:0] right_power;
		drive_mode_t        drive_mode;
	} out_item_t;

	typedef struct packed {
		logic [7:0]         white_left;
		logic [7:0]         white_right;
		logic [7:0]         black_left;
		logic [7:0]         black_right;
		logic [7:0]         near_black_limit;
		logic [7:0]         off_line_limit;
		logic [POWER_W-1:0] forward_speed;
		logic [7:0]         steer_gain_tenths;
	} cfg_t;

	// Item travelling down the angle cells
	typedef struct packed {
		logic [SAMPLE_W-1:0] dl;
		logic [SAMPLE_W-1:0] dr;
		logic [ANG_W-1:0]    acc;
		drive_mode_t         mode;
	} cell_data_t;

	typedef logic [TAB_DEPTH-1:0][TRIG_W-1:0] trig_tab_t;

	// Long division of non-negative values; only used while the tables are built
	function automatic longint lfs_udiv(input longint num, input longint den);
		longint q, rem;
		int b;
		q   = 0;
		rem = 0;
		for (b = 62; b >= 0; b--) begin
			rem = (rem <<< 1) | ((num >>> b) & longint'(1));
			if (rem >= den) begin
				rem = rem - den;
				q   = q | (longint'(1) <<< b);
			end
		end
		return q;
	endfunction

	// Q30 sine or cosine of k*157/9000 rad, truncated Taylor series, k = 1..89
	function automatic trig_tab_t lfs_build_tab(input bit want_cos);
		trig_tab_t tab;
		longint x, x2, ts, tc, ss, cc;
		int k, n;
		tab = '0;
		for (k = 1; k <= ANGLE_MAX; k++) begin
			x  = lfs_udiv((longint'(k) * 157 <<< 30) + 4500, longint'(9000));
			x2 = (x * x) >>> 30;
			ts = x;
			tc = longint'(1) <<< 30;
			ss = 0;
			cc = 0;
			for (n = 0; n < 16; n++) begin
				if ((n & 1) != 0) begin
					ss = ss - ts;
					cc = cc - tc;
				end else begin
					ss = ss + ts;
					cc = cc + tc;
				end
				ts = lfs_udiv((ts * x2) >>> 30, longint'((2 * n + 2) * (2 * n + 3)));
				tc = lfs_udiv((tc * x2) >>> 30, longint'((2 * n + 1) * (2 * n + 2)));
			end
			tab[k] = want_cos ? cc[TRIG_W-1:0] : ss[TRIG_W-1:0];
		end
		return tab;
	endfunction

	localparam trig_tab_t SIN_TAB = lfs_build_tab(1'b0);
	localparam trig_tab_t COS_TAB = lfs_build_tab(1'b1);

endpackage

[design/lfs_front.sv]
// ----------------------------------------------------------------------------
// lfs_front
// Clamps the samples to white, forms the squared distance to black and picks
// the drive mode; hands the differences to the angle cells.
// ----------------------------------------------------------------------------
module lfs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  lfs_pkg::in_item_t  item_in,
	input  lfs_pkg::cfg_t      cfg,
	output logic               out_valid,
	output lfs_pkg::cell_data_t out_data
);
	import lfs_pkg::*;

	logic [SAMPLE_W-1:0] l_clamp, r_clamp;
	logic signed [8:0]   dist_a, dist_b;
	logic signed [17:0]  sq_a_full, sq_b_full;
	logic [15:0]         sq_a_s1, sq_b_s1;
	logic [SAMPLE_W-1:0] dl_s1, dr_s1;
	logic                valid_s1, valid_s2;
	logic [16:0]         d2;
	logic [15:0]         near_sq, off_sq;
	drive_mode_t         mode;
	cell_data_t          data_s2;

	// Raise each sample to its white level
	assign l_clamp = (item_in.left_sample < cfg.white_left) ? cfg.white_left
		: item_in.left_sample;
	assign r_clamp = (item_in.right_sample < cfg.white_right) ? cfg.white_right
		: item_in.right_sample;

	assign dist_a    = $signed({1'b0, cfg.black_left}) - $signed({1'b0, l_clamp});
	assign dist_b    = $signed({1'b0, cfg.black_right}) - $signed({1'b0, r_clamp});
	assign sq_a_full = dist_a * dist_a;
	assign sq_b_full = dist_b * dist_b;

	// Stage 1: squares and white differences
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		sq_a_s1 <= sq_a_full[15:0];
		sq_b_s1 <= sq_b_full[15:0];
		dl_s1   <= l_clamp - cfg.white_left;
		dr_s1   <= r_clamp - cfg.white_right;
	end

	// Distance against the squared limits
	assign d2      = {1'b0, sq_a_s1} + {1'b0, sq_b_s1};
	assign near_sq = 16'(cfg.near_black_limit) * 16'(cfg.near_black_limit);
	assign off_sq  = 16'(cfg.off_line_limit) * 16'(cfg.off_line_limit);

	always_comb begin
		if (d2 < {1'b0, near_sq}) begin
			mode = MODE_STRAIGHT;
		end else if (d2 > {1'b0, off_sq}) begin
			mode = MODE_SPIN;
		end else begin
			mode = MODE_STEER;
		end
	end

	// Stage 2: mode decided, search accumulator cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		data_s2.dl   <= dl_s1;
		data_s2.dr   <= dr_s1;
		data_s2.acc  <= '0;
		data_s2.mode <= mode;
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

[design/lfs_angle_cell.sv]
// ----------------------------------------------------------------------------
// lfs_angle_cell
// One step of the angle search: tries one bit of the angle with a tangent
// compare dl*cos >= dr*sin and passes the item on to the next cell.
// ----------------------------------------------------------------------------
module lfs_angle_cell #(
	parameter int unsigned STEP_BIT = lfs_pkg::ANGLE_STEPS - 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  lfs_pkg::cell_data_t in_data,
	output logic                out_valid,
	output lfs_pkg::cell_data_t out_data
);
	import lfs_pkg::*;

	localparam int unsigned PROD_W = SAMPLE_W + TRIG_W;
	localparam logic [ANG_W-1:0] STEP_MASK = ANG_W'(1) << STEP_BIT;

	logic [ANG_W-1:0]  cand;
	logic [TRIG_W-1:0] sin_v, cos_v;
	logic [PROD_W-1:0] lhs, rhs;
	logic              pass;
	logic              valid_s1;
	cell_data_t        data_s1;

	// Candidate angle with this bit set
	assign cand  = in_data.acc | STEP_MASK;
	assign sin_v = SIN_TAB[cand];
	assign cos_v = COS_TAB[cand];
	assign lhs   = PROD_W'(in_data.dl) * PROD_W'(cos_v);
	assign rhs   = PROD_W'(in_data.dr) * PROD_W'(sin_v);
	assign pass  = (cand <= ANG_W'(ANGLE_MAX)) && (lhs >= rhs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1.dl   <= in_data.dl;
		data_s1.dr   <= in_data.dr;
		data_s1.acc  <= pass ? cand : in_data.acc;
		data_s1.mode <= in_data.mode;
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

[design/lfs_mix.sv]
// ----------------------------------------------------------------------------
// lfs_mix
// Turns the angle into a steering error, scales it by the gain and mixes it
// into the two motor powers in steer mode; registers the result and its strobe.
// ----------------------------------------------------------------------------
module lfs_mix (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  lfs_pkg::cell_data_t in_data,
	input  lfs_pkg::cfg_t       cfg,
	output logic                done,
	output lfs_pkg::out_item_t  result
);
	import lfs_pkg::*;

	logic [ANG_W-1:0]   angle;
	logic signed [7:0]  diff;
	logic signed [8:0]  gain_s;
	logic signed [15:0] prod;
	logic [13:0]        prod_mag;
	logic [10:0]        err_mag;
	logic [POWER_W-1:0] err_clamp;
	logic [26:0]        m_full;
	logic [POWER_W-1:0] fwd_sat;
	logic signed [8:0]  fs_plus, fs_minus;
	logic [POWER_W-1:0] sat_plus, sat_minus;
	out_item_t          res_next;

	logic signed [15:0] prod_s1;
	logic [26:0]        scaled_s2;
	logic [13:0]        mprod_s3;
	logic [POWER_W-1:0] m_s4;
	logic               neg_s2, neg_s3, neg_s4;
	drive_mode_t        mode_s1, mode_s2, mode_s3, mode_s4;
	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic               done_q;
	out_item_t          result_q;

	// Clamp a signed mix to the power range
	function automatic logic [POWER_W-1:0] sat_power(input logic signed [8:0] v);
		logic [POWER_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > 9'sd100) begin
			r = POWER_W'(POWER_MAX);
		end else begin
			r = v[POWER_W-1:0];
		end
		return r;
	endfunction

	// Stage 1: error before scaling, (45 - angle) * gain
	assign angle  = (in_data.dr == '0) ? ANG_W'(ANGLE_VERT) : in_data.acc;
	assign diff   = 8'sd45 - $signed({1'b0, angle});
	assign gain_s = $signed({1'b0, cfg.steer_gain_tenths});
	assign prod   = 16'(diff) * 16'(gain_s);

	// Stage 2: magnitude times reciprocal of ten
	assign prod_mag = prod_s1[15] ? 14'(-prod_s1) : prod_s1[13:0];

	// Stage 3: truncated error, clamped to 100, times forward speed
	assign err_mag   = scaled_s2[RECIP10_SH +: 11];
	assign err_clamp = (err_mag > 11'(POWER_MAX)) ? POWER_W'(POWER_MAX) : err_mag[POWER_W-1:0];

	// Stage 4: divide by a hundred through the reciprocal
	assign m_full = 27'(mprod_s3) * 27'(RECIP100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done_q   <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1   <= prod;
		mode_s1   <= in_data.mode;
		scaled_s2 <= 27'(prod_mag) * 27'(RECIP10);
		neg_s2    <= prod_s1[15];
		mode_s2   <= mode_s1;
		mprod_s3  <= 14'(err_clamp) * 14'(cfg.forward_speed);
		neg_s3    <= neg_s2;
		mode_s3   <= mode_s2;
		m_s4      <= m_full[RECIP100_SH +: POWER_W];
		neg_s4    <= neg_s3;
		mode_s4   <= mode_s3;
		result_q  <= res_next;
	end

	// Output mix
	assign fwd_sat   = (cfg.forward_speed > POWER_W'(POWER_MAX)) ? POWER_W'(POWER_MAX)
		: cfg.forward_speed;
	assign fs_plus   = $signed({2'b0, cfg.forward_speed}) + $signed({2'b0, m_s4});
	assign fs_minus  = $signed({2'b0, cfg.forward_speed}) - $signed({2'b0, m_s4});
	assign sat_plus  = sat_power(fs_plus);
	assign sat_minus = sat_power(fs_minus);

	always_comb begin
		res_next.drive_mode = mode_s4;
		case (mode_s4)
			MODE_STRAIGHT: begin
				res_next.left_power  = fwd_sat;
				res_next.right_power = fwd_sat;
			end
			MODE_SPIN: begin
				res_next.left_power  = '0;
				res_next.right_power = fwd_sat;
			end
			default: begin
				// negative error steers the other way
				res_next.left_power  = neg_s4 ? sat_minus : sat_plus;
				res_next.right_power = neg_s4 ? sat_plus : sat_minus;
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[design/line_follow_steering.sv]
// ----------------------------------------------------------------------------
// line_follow_steering
// Line follow steering controller: two reflectance samples in, two motor
// powers and a drive mode out. Front end, a row of angle search cells and a
// mixing back end, all pipelined.
//
//   channel   handshake           payload
//   input     start, busy         item_in   (left_sample, right_sample)
//   result    done (one cycle)    result    (left_power, right_power, drive_mode)
//   config    cfg_we              cfg_index, cfg_data
//
// One item per cycle; busy is never raised. Each result passes through two front
// stages, seven angle cells (one angle bit each) and five mixing and output
// stages. Reset clears the stage valids and loads the register defaults. The
// receiver cannot stall; results are strobed once.
// ----------------------------------------------------------------------------
`include "line_follow_steering_defines.svh"

module line_follow_steering (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  lfs_pkg::in_item_t                  item_in,
	output logic                               done,
	output lfs_pkg::out_item_t                 result,
	input  logic                               cfg_we,
	input  logic [lfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lfs_pkg::CFG_W-1:0]          cfg_data
);
	import lfs_pkg::*;

	cfg_t       cfg_q;
	logic       front_valid;
	cell_data_t front_data;
	logic       chain_valid [0:ANGLE_STEPS];
	cell_data_t chain_data  [0:ANGLE_STEPS];

	assign busy = 1'b0;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.white_left        <= 8'd170;
			cfg_q.white_right       <= 8'd170;
			cfg_q.black_left        <= 8'd212;
			cfg_q.black_right       <= 8'd212;
			cfg_q.near_black_limit  <= 8'd10;
			cfg_q.off_line_limit    <= 8'd50;
			cfg_q.forward_speed     <= 7'd30;
			cfg_q.steer_gain_tenths <= 8'd25;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_WHITE_LEFT:  cfg_q.white_left        <= cfg_data;
				CFG_WHITE_RIGHT: cfg_q.white_right       <= cfg_data;
				CFG_BLACK_LEFT:  cfg_q.black_left        <= cfg_data;
				CFG_BLACK_RIGHT: cfg_q.black_right       <= cfg_data;
				CFG_NEAR_LIMIT:  cfg_q.near_black_limit  <= cfg_data;
				CFG_OFF_LIMIT:   cfg_q.off_line_limit    <= cfg_data;
				CFG_FWD_SPEED:   cfg_q.forward_speed     <= cfg_data[POWER_W-1:0];
				CFG_STEER_GAIN:  cfg_q.steer_gain_tenths <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item_in   (item_in),
		.cfg       (cfg_q),
		.out_valid (front_valid),
		.out_data  (front_data)
	);

	assign chain_valid[0] = front_valid;
	assign chain_data[0]  = front_data;

	// Angle search cells, most significant angle bit first
	for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_cell
		lfs_angle_cell #(
			.STEP_BIT (ANGLE_STEPS - 1 - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	lfs_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_valid[ANGLE_STEPS]),
		.in_data  (chain_data[ANGLE_STEPS]),
		.cfg      (cfg_q),
		.done     (done),
		.result   (result)
	);

	// Checks
	`LFS_ASSERT_DLY(a_latency, start, PIPE_LATENCY, done, "result missing after fixed latency")
	`LFS_ASSERT_IMP(a_power_range, done, (result.left_power <= 7'd100) && (result.right_power <= 7'd100), "power out of range")
	`LFS_ASSERT_IMP(a_spin_left_off, done && (result.drive_mode == MODE_SPIN), result.left_power == '0, "spin with left motor on")
	`LFS_ASSERT_IMP(a_straight_equal, done && (result.drive_mode == MODE_STRAIGHT), result.left_power == result.right_power, "straight with unequal powers")

endmodule
